FILE: hdl/prd_pkg.sv
// Package for the pair-escaped run-length decoder.
// Holds the count width, the decoder state and result types.
// Depends on nothing.
`timescale 1ns / 1ps

package prd_pkg;

  // Width of the run count; equal to the width of repeat_res.
  localparam int COUNT_BITS   = 32;
  localparam int GROUP_BITS   = 7;
  // Count groups that land at least partly inside the count.
  localparam int COUNT_GROUPS = (COUNT_BITS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int GROUP_IDX_W  = $clog2(COUNT_GROUPS + 1);

  localparam logic [7:0] GROUP_MASK = 8'h7F;
  localparam logic [7:0] MORE_FLAG  = 8'h80;

  typedef struct packed {
    logic [7:0]             last_value;
    logic                   last_valid;
    logic                   reading_count;
    logic [COUNT_BITS-1:0]  count_accum;
    logic [GROUP_IDX_W-1:0] group_index;
    logic                   overflow_seen;
  } dec_state_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  value;
    logic [31:0] repeat_res;
    logic        count_overflow;
  } dec_result_t;

endpackage

FILE: hdl/prd_if.sv
// Valid/ready channel interfaces for the decoder's input and result streams.
// Depends on nothing.
`timescale 1ns / 1ps

interface prd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       restart;

  modport source (output valid, output code_byte, output restart, input ready);
  modport sink   (input valid, input code_byte, input restart, output ready);
endinterface

interface prd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  value;
  logic [31:0] repeat_res;
  logic        count_overflow;

  modport source (output valid, output value, output repeat_res, output count_overflow,
                  input ready);
  modport sink   (input valid, input value, input repeat_res, input count_overflow,
                  output ready);
endinterface

FILE: hdl/prd_step.sv
// Next-state and result logic for one compressed byte.
// Depends on prd_pkg.
`timescale 1ns / 1ps

module prd_step
  import prd_pkg::*;
(
  input  dec_state_t  state_i,
  input  logic [7:0]  code_byte_i,
  input  logic        restart_i,
  output dec_state_t  state_o,
  output dec_result_t result_o
);

  dec_state_t                  st;
  logic [GROUP_BITS-1:0]       grp;
  logic [COUNT_BITS+GROUP_BITS-1:0] shifted;
  logic                        in_range;
  logic [COUNT_BITS-1:0]       acc_new;
  logic                        ovf_new;
  logic                        pair;

  always_comb begin
    st       = restart_i ? '0 : state_i;
    grp      = code_byte_i[GROUP_BITS-1:0] & GROUP_MASK[GROUP_BITS-1:0];
    in_range = (st.group_index < GROUP_IDX_W'(COUNT_GROUPS));
    shifted  = {{COUNT_BITS{1'b0}}, grp} << (GROUP_BITS * int'(st.group_index));
    if (in_range) begin
      acc_new = st.count_accum | shifted[COUNT_BITS-1:0];
      ovf_new = st.overflow_seen | (|shifted[COUNT_BITS+GROUP_BITS-1:COUNT_BITS]);
    end else begin
      acc_new = st.count_accum;
      ovf_new = 1'b1;
    end
    pair     = st.last_valid && (st.last_value == code_byte_i);

    state_o  = st;
    result_o = '0;

    if (st.reading_count) begin
      if ((code_byte_i & MORE_FLAG) != 8'h00) begin
        // More groups follow: accumulate, saturate the index
        state_o.count_accum   = acc_new;
        state_o.overflow_seen = ovf_new;
        if (in_range) begin
          state_o.group_index = st.group_index + GROUP_IDX_W'(1);
        end
      end else begin
        state_o.reading_count = 1'b0;
        state_o.count_accum   = '0;
        state_o.group_index   = '0;
        state_o.overflow_seen = 1'b0;
        // Zero count: drop, keep the pair value valid
        if (acc_new != '0) begin
          result_o.valid          = 1'b1;
          result_o.value          = st.last_value;
          result_o.repeat_res     = acc_new;
          result_o.count_overflow = ovf_new;
          state_o.last_valid      = 1'b0;
          state_o.last_value      = '0;
        end
      end
    end else begin
      state_o.reading_count   = pair;
      state_o.count_accum     = '0;
      state_o.group_index     = '0;
      state_o.overflow_seen   = 1'b0;
      state_o.last_value      = code_byte_i;
      state_o.last_valid      = 1'b1;
      result_o.valid          = 1'b1;
      result_o.value          = code_byte_i;
      result_o.repeat_res     = 32'd1;
      result_o.count_overflow = 1'b0;
    end
  end

endmodule

FILE: hdl/pair_rle_varint_decoder.sv
// Top level of the pair-escaped run-length decoder with base-128 counts.
// Depends on prd_pkg, prd_in_if, prd_out_if and prd_step.
//
// Usage:
//   in_i takes one compressed byte per transaction, with a restart flag that
//   clears all decoder state before that byte is decoded. out_o gives at most
//   one result per byte: a literal (repeat_res 1) or a run (value, count and
//   an overflow flag when count bits were dropped). Of the count bytes only the
//   final one can give a result, and runs of zero length give no result.
//   A byte accepted on in_i passes the input register and then the result
//   register before its result appears on out_o.
//   Throughput: one byte per cycle while the receiver takes results; the
//   decoder state loop through prd_step is combinational.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_i.ready drops once both are occupied and rises again
//   in the cycle the result is taken.
//   Reset clears the decoder state and both valid flags; no item is lost
//   or duplicated across a stall.
`timescale 1ns / 1ps

module pair_rle_varint_decoder
  import prd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  prd_in_if.sink     in_i,
  prd_out_if.source  out_o
);

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_restart_q;
  dec_state_t  state_q, state_d;
  dec_result_t step_res;
  logic        out_valid_q;
  logic [7:0]  out_value_q;
  logic [31:0] out_repeat_q;
  logic        out_ovf_q;
  logic        out_free;
  logic        s1_fire;
  logic        s1_ready;

  assign out_free  = !out_valid_q || out_o.ready;
  assign s1_fire   = s1_valid_q && out_free;
  assign s1_ready  = !s1_valid_q || out_free;
  assign in_i.ready = s1_ready;

  prd_step u_step (
    .state_i     (state_q),
    .code_byte_i (s1_byte_q),
    .restart_i   (s1_restart_q),
    .state_o     (state_d),
    .result_o    (step_res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_i.valid) begin
      s1_byte_q    <= in_i.code_byte;
      s1_restart_q <= in_i.restart;
    end
  end

  // Decoder state advances once per decoded byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_fire) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_fire && step_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && step_res.valid) begin
      out_value_q  <= step_res.value;
      out_repeat_q <= step_res.repeat_res;
      out_ovf_q    <= step_res.count_overflow;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.value          = out_value_q;
  assign out_o.repeat_res     = out_repeat_q;
  assign out_o.count_overflow = out_ovf_q;

  // A result never carries a zero count
  a_nonzero_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_repeat_q != 32'd0))
    else $error("result with zero repeat count");

  // Outside a count the accumulator is empty
  a_idle_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.reading_count |-> (state_q.count_accum == '0 && state_q.group_index == '0
                                && !state_q.overflow_seen))
    else $error("count state left over outside a count");

  // A literal result never flags overflow
  a_literal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && step_res.valid && (s1_restart_q || !state_q.reading_count))
    |-> (!step_res.count_overflow && step_res.repeat_res == 32'd1))
    else $error("literal result with overflow flag");

  // A stalled byte holds in the input register
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_byte_q)))
    else $error("input register changed while stalled");

  // While reading a count no pair may be pending release of last_valid
  a_reading_needs_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.reading_count |-> state_q.last_valid)
    else $error("count read without a pair value");

endmodule
